>>> rtl/animated_seven_segment_counter_unit_assert.svh
// Assertion macros for the animated seven-segment counter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ANIMATED_SEVEN_SEGMENT_COUNTER_UNIT_ASSERT_SVH
`define ANIMATED_SEVEN_SEGMENT_COUNTER_UNIT_ASSERT_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asc check failed");

// Check that the antecedent implies the consequent in the next cycle.
`define ASC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asc check failed");

`endif

>>> rtl/asc_pkg.sv
// Shared constants and the segment code table of the counter.
// No dependencies.
package asc_pkg;

    localparam int VALUE_W     = 27;
    localparam int BCD_DIGITS  = 8;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int SEG_W       = 7;
    localparam int SEGS_W      = 56;
    localparam int POS_W       = 4;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 27'd99999999;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/asc_bcd.sv
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
// Depends on asc_pkg.
module asc_bcd
    import asc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic [BCD_W-1:0]   bcd
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BCD_W-1:0]   adj;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                        : bcd_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            bcd_reg  <= bcd_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> rtl/animated_seven_segment_counter_unit.sv
// Animated seven-segment counter: one transaction in, one result out.
// Set target, idle tick and unused op go straight to the result; a tick at target compares
// goal and shown only; set value runs the 27-step BCD conversion; a moving tick subtracts
// (twice when it counts down), divides by ten, steps and converts. One transaction at a time,
// the next accepted in the cycle after the result loads. Reset (rst_n, async, low) clears
// value, target and flags, digits to 1. Depends on asc_pkg, asc_bcd and the assertion macros.
`include "animated_seven_segment_counter_unit_assert.svh"

module animated_seven_segment_counter_unit
    import asc_pkg::*;
#(
    parameter int DIGITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // new_value[26:0], zero fill
    input  logic [OP_W-1:0]        s_tuser,   // op[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // shown_value[26:0], digit_count[30:27],
                                              // segments[86:31], zero fill
    output logic [OUT_TUSER_W-1:0] m_tuser,   // moving[0], active[1]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [POS_W-1:0]       cfg_data
);

    localparam int          RECIP_W     = 28;
    localparam int          RECIP_SHIFT = 31;
    localparam int          PROD_W      = VALUE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 28'hCCCCCCD;
    localparam logic [4:0]  DIGITS_V = 5'(DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_GS,
        ST_SUB_SG,
        ST_DIVIDE,
        ST_APPLY,
        ST_CONVERT,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     shown_reg, shown_next;
    logic [VALUE_W-1:0]     goal_reg, goal_next;
    logic [POS_W-1:0]       positions_reg, positions_next;
    logic                   running_reg, running_next;
    logic                   moved_reg, moved_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_W-1:0]     work_reg, work_next;
    logic [POS_W-1:0]       min_digits_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                   s_accept;
    logic [VALUE_W-1:0]     new_value;
    logic [VALUE_W-1:0]     add_a, add_b;
    logic                   add_sub;
    logic [VALUE_W:0]       add_res;
    logic [VALUE_W-1:0]     delta;
    logic [PROD_W-1:0]      prod;
    logic [VALUE_W-1:0]     quot;
    logic                   bcd_start;
    logic                   bcd_done;
    logic [BCD_W-1:0]       bcd;
    logic [POS_W-1:0]       value_digits;
    logic [4:0]             eff_min;
    logic [4:0]             count_w;
    logic [SEGS_W-1:0]      segs;

    asc_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (shown_reg),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign new_value = (s_tdata[VALUE_W-1:0] > VALUE_MAX) ? VALUE_MAX : s_tdata[VALUE_W-1:0];
    assign bcd_start = (state_reg == ST_CONVERT);
    assign delta     = (work_reg == '0) ? VALUE_W'(1) : work_reg;

    always_comb
    begin
        case (state_reg)
            ST_SUB_SG:
            begin
                add_a   = shown_reg;
                add_b   = goal_reg;
                add_sub = 1'b1;
            end
            ST_APPLY:
            begin
                add_a   = shown_reg;
                add_b   = delta;
                add_sub = neg_reg;
            end
            default:
            begin
                add_a   = goal_reg;
                add_b   = shown_reg;
                add_sub = 1'b1;
            end
        endcase
    end

    assign add_res = {1'b0, add_a} + ({1'b0, add_b} ^ {(VALUE_W + 1){add_sub}})
                   + (VALUE_W + 1)'(add_sub);

    assign prod = work_reg * RECIP_TEN;
    assign quot = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);

    always_comb
    begin
        value_digits = '0;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd[4*k +: 4] != 4'd0)
            begin
                value_digits = POS_W'(k + 1);
            end
        end
        eff_min = (min_digits_reg == '0) ? 5'd1 : {1'b0, min_digits_reg};
        if (eff_min > DIGITS_V)
        begin
            eff_min = DIGITS_V;
        end
        count_w = ({1'b0, value_digits} < eff_min) ? eff_min : {1'b0, value_digits};
        if (count_w > DIGITS_V)
        begin
            count_w = DIGITS_V;
        end
    end

    always_comb
    begin
        segs = '0;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (POS_W'(k) < positions_reg)
            begin
                segs[SEG_W*k +: SEG_W] = seg_code(bcd[4*k +: 4]);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        shown_next     = shown_reg;
        goal_next      = goal_reg;
        positions_next = positions_reg;
        running_next   = running_reg;
        moved_next     = moved_reg;
        neg_next       = neg_reg;
        work_next      = work_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    moved_next = 1'b0;
                    case (s_tuser)
                        OP_TICK:
                        begin
                            state_next = running_reg ? ST_SUB_GS : ST_EMIT;
                        end
                        OP_TARGET:
                        begin
                            goal_next    = new_value;
                            running_next = 1'b1;
                            state_next   = ST_EMIT;
                        end
                        OP_LOAD:
                        begin
                            shown_next = new_value;
                            state_next = ST_CONVERT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SUB_GS:
            begin
                if (add_res == '0)
                begin
                    running_next = 1'b0;
                    state_next   = ST_EMIT;
                end
                else if (add_res[VALUE_W])
                begin
                    neg_next   = 1'b1;
                    state_next = ST_SUB_SG;
                end
                else
                begin
                    neg_next   = 1'b0;
                    work_next  = add_res[VALUE_W-1:0];
                    state_next = ST_DIVIDE;
                end
            end
            ST_SUB_SG:
            begin
                work_next  = add_res[VALUE_W-1:0];
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                work_next  = quot;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                shown_next = add_res[VALUE_W-1:0];
                moved_next = 1'b1;
                state_next = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (bcd_done)
                begin
                    positions_next = count_w[POS_W-1:0];
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, segs, positions_reg, shown_reg};
                    m_tuser_next  = {running_reg, moved_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            shown_reg      <= '0;
            goal_reg       <= '0;
            positions_reg  <= POS_W'(1);
            running_reg    <= 1'b0;
            moved_reg      <= 1'b0;
            min_digits_reg <= POS_W'(1);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_reg     <= shown_next;
            goal_reg      <= goal_next;
            positions_reg <= positions_next;
            running_reg   <= running_next;
            moved_reg     <= moved_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                min_digits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        work_reg    <= work_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASC_ASSERT_SAME(a_count_nonzero, m_tvalid, m_tdata[30:27] != 4'd0)
    `ASC_ASSERT_SAME(a_moving_active, m_tvalid && m_tuser[0], m_tuser[1])
    `ASC_ASSERT_SAME(a_shown_range, 1'b1, shown_reg <= VALUE_MAX && goal_reg <= VALUE_MAX)
    `ASC_ASSERT_NEXT(a_divide_one_cycle, state_reg == ST_DIVIDE, state_reg == ST_APPLY)

endmodule

>>> dv/animated_seven_segment_counter_unit_tb.sv
// Self-checking testbench for animated_seven_segment_counter_unit: drives set-value,
// set-target, tick and unused commands under random handshake gaps and checks each readout.
// Depends on asc_pkg and the counter RTL; expected readouts come from an in-bench model.
module animated_seven_segment_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asc_pkg::*;

    localparam int DIGITS = 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 96;
    localparam int STALL_AFTER = 250;
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [POS_W-1:0] FIRST_MINS [5] = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5};
    localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [VALUE_W-1:0] shown;
        logic [POS_W-1:0]   count;
        logic [SEGS_W-1:0]  segs;
        logic               moving;
        logic               active;
    } readout_t;

    typedef struct {
        logic     fixed;
        readout_t r;
    } fixed_tag_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               fixed;
        readout_t           r;
    } stim_row_t;

    localparam readout_t AT_ZERO = {27'd0, 4'd1, 56'h3F, 1'b0, 1'b0};
    localparam readout_t AT_ZERO_ARMED = {27'd0, 4'd1, 56'h3F, 1'b0, 1'b1};
    localparam readout_t AT_MAX = {VALUE_MAX, 4'd8, {8{7'h6F}}, 1'b0, 1'b0};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [POS_W-1:0]       cfg_data = '0;

    animated_seven_segment_counter_unit #(
        .DIGITS(DIGITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    logic [VALUE_W-1:0] pv_shown = '0;
    logic [VALUE_W-1:0] pv_goal = '0;
    logic [POS_W-1:0]   pv_pos = 4'd1;
    logic               pv_run = 1'b0;
    logic [POS_W-1:0]   pv_min = 4'd1;

    readout_t   readout_q [$];
    fixed_tag_t fixed_q [$];
    stim_row_t  dir_rows [$];

    int  errors = 0;
    int  items_sent = 0;
    int  counted = 0;
    int  results_done = 0;
    int  moving_seen = 0;
    int  idle_cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    bit  stall_done = 1'b0;

    function automatic void show_value(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        int n;
        int floor_n;
        rest = v;
        n = 0;
        floor_n = (pv_min == 0) ? 1 : ((pv_min > DIGITS) ? DIGITS : int'(pv_min));
        while (rest != 0)
        begin
            n++;
            rest = rest / 10;
        end
        if (n < floor_n)
            n = floor_n;
        if (n > DIGITS)
            n = DIGITS;
        pv_shown = v;
        pv_pos = n[POS_W-1:0];
    endfunction

    function automatic readout_t advance_counter(input logic [OP_W-1:0] op,
                                                 input logic [VALUE_W-1:0] raw);
        readout_t res;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] rest;
        longint diff;
        longint delta;
        v = (raw > VALUE_MAX) ? VALUE_MAX : raw;
        res = '0;
        case (op)
            OP_TICK:
            begin
                if (pv_run)
                begin
                    if (pv_shown != pv_goal)
                    begin
                        diff = longint'(pv_goal) - longint'(pv_shown);
                        delta = diff / 10;
                        if (delta == 0)
                            delta = (diff > 0) ? 1 : -1;
                        show_value(VALUE_W'(longint'(pv_shown) + delta));
                        res.moving = 1'b1;
                    end
                    else
                    begin
                        pv_run = 1'b0;
                    end
                end
            end
            OP_TARGET:
            begin
                pv_goal = v;
                pv_run = 1'b1;
            end
            OP_LOAD:
            begin
                show_value(v);
            end
            default:
            begin
            end
        endcase
        res.shown = pv_shown;
        res.count = pv_pos;
        rest = pv_shown;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (k < pv_pos && k * SEG_W + SEG_W <= SEGS_W)
            begin
                res.segs[SEG_W*k +: SEG_W] = DIGIT_SEG[rest % 10];
                rest = rest / 10;
            end
        end
        res.active = pv_run;
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = VALUE_W'($urandom_range(0, 99));
            1: v = VALUE_W'($urandom_range(0, 99999));
            2: v = VALUE_W'($urandom_range(0, VALUE_MAX));
            3: v = VALUE_W'($urandom_range(VALUE_MAX, 27'h7FFFFFF));
            default: v = VALUE_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Predict on input acceptance, check on output acceptance, track register writes.
    always @(posedge clk)
    begin : scoreboard
        readout_t got;
        readout_t want;
        fixed_tag_t tag;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.shown = m_tdata[26:0];
                got.count = m_tdata[30:27];
                got.segs = m_tdata[86:31];
                got.moving = m_tuser[0];
                got.active = m_tuser[1];
                if (readout_q.size() == 0)
                begin
                    $error("readout with no transaction pending: shown_value 0x%0h", got.shown);
                    errors++;
                end
                else
                begin
                    want = readout_q.pop_front();
                    compare_field("shown_value", want.shown, got.shown);
                    compare_field("digit_count", want.count, got.count);
                    compare_field("segments", want.segs, got.segs);
                    compare_field("moving", want.moving, got.moving);
                    compare_field("active", want.active, got.active);
                    results_done++;
                    if (got.moving)
                        moving_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_counter(s_tuser, s_tdata[VALUE_W-1:0]);
                tag = fixed_q.pop_front();
                if (tag.fixed)
                    want = tag.r;
                readout_q.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                pv_min = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("animated_seven_segment_counter_unit test failed");
            $finish;
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the block.
    initial
    begin : rx_side
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if (!stall_done && results_done >= STALL_AFTER)
            begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input logic fixed, input readout_t r);
        int gap;
        fixed_tag_t tag;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.fixed = fixed;
        tag.r = r;
        fixed_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(IN_TDATA_W-VALUE_W){1'b0}}, value};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (op != OP_UNUSED)
            counted++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_done < items_sent)
            @(posedge clk);
    endtask

    task automatic write_min(input logic [POS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic fixed, input readout_t r);
        stim_row_t row;
        row.op = op;
        row.value = value;
        row.fixed = fixed;
        row.r = r;
        dir_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        int start;
        int kind;
        logic [POS_W-1:0] min_val;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_TICK, 27'd0, 1'b1, AT_ZERO);
        add_row(OP_UNUSED, 27'h7FFFFFF, 1'b1, AT_ZERO);
        add_row(OP_LOAD, 27'h7FFFFFF, 1'b1, AT_MAX);
        add_row(OP_LOAD, 27'd0, 1'b1, AT_ZERO);
        add_row(OP_TARGET, 27'd0, 1'b1, AT_ZERO_ARMED);
        add_row(OP_TICK, 27'h7FFFFFF, 1'b1, AT_ZERO);
        add_row(OP_TICK, 27'd0, 1'b1, AT_ZERO);
        add_row(OP_LOAD, 27'h2AAAAAA, 1'b0, '0);
        add_row(OP_UNUSED, 27'h5555555, 1'b0, '0);
        add_row(OP_TARGET, 27'h5555555, 1'b0, '0);
        repeat (3) add_row(OP_TICK, 27'h2AAAAAA, 1'b0, '0);
        add_row(OP_LOAD, 27'd5, 1'b0, '0);
        add_row(OP_TARGET, 27'd3, 1'b0, '0);
        repeat (3) add_row(OP_TICK, 27'd0, 1'b0, '0);
        add_row(OP_LOAD, VALUE_MAX, 1'b0, '0);
        add_row(OP_TARGET, 27'd0, 1'b0, '0);
        repeat (3) add_row(OP_TICK, 27'd0, 1'b0, '0);
        add_row(OP_TARGET, 27'd12345678, 1'b0, '0);
        add_row(OP_TICK, 27'd0, 1'b0, '0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].r);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            min_val = (p < 5) ? FIRST_MINS[p] : POS_W'($urandom_range(0, 15));
            write_min(min_val);
            tx_steady = (p % 4 == 3);
            rx_steady = (p % 4 >= 2);
            start = counted;
            while (counted - start < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 8)
                begin
                    if ($urandom_range(0, 2) != 0)
                        send_item(OP_LOAD, pick_value(), 1'b0, '0);
                    send_item(OP_TARGET, pick_value(), 1'b0, '0);
                    repeat ($urandom_range(1, 40))
                        send_item(OP_TICK, VALUE_W'($urandom()), 1'b0, '0);
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(OP_W'($urandom_range(0, 3)), VALUE_W'($urandom()), 1'b0, '0);
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (readout_q.size() != 0)
        begin
            $error("%0d expected readouts never arrived", readout_q.size());
            errors++;
        end
        $display("Covered %0d commands, %0d readouts checked, %0d moving ticks,",
                 counted, results_done, moving_seen);
        $display("over %0d min_digits settings including 0, 8 and 15.", PHASES + 1);
        if (errors == 0)
            $display("animated_seven_segment_counter_unit test passed");
        else
            $display("animated_seven_segment_counter_unit test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/asc_pkg.sv
rtl/asc_bcd.sv
rtl/animated_seven_segment_counter_unit.sv
dv/animated_seven_segment_counter_unit_tb.sv
